@@ hdl/hcbd_pkg.sv @@
// Shared types, constants and helpers for the chunked body decoder.
`timescale 1ns / 1ps
`default_nettype none
package hcbd_pkg;

  localparam int SIZE_BITS = 32;
  localparam int CNT_BITS  = 4;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  localparam logic [1:0] STATUS_HEADER  = 2'd0;
  localparam logic [1:0] STATUS_FRAMING = 2'd1;
  localparam logic [1:0] STATUS_DONE    = 2'd2;
  localparam logic [1:0] STATUS_ERROR   = 2'd3;

  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_SIZE    = 8'b0000_0010,
    PH_SIZE_LF = 8'b0000_0100,
    PH_DATA    = 8'b0000_1000,
    PH_DATA_CR = 8'b0001_0000,
    PH_DATA_LF = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_t;

  // Classified byte as it travels from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [1:0] status_of(phase_t ph);
    logic [1:0] s;
    case (ph)
      PH_HEADER: s = STATUS_HEADER;
      PH_DONE:   s = STATUS_DONE;
      PH_ERROR:  s = STATUS_ERROR;
      default:   s = STATUS_FRAMING;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ hdl/http_chunked_body_decoder.sv @@
// Top level of the HTTP/1.1 chunked body decoder.
`timescale 1ns / 1ps
`default_nettype none
// One result beat per input beat, one beat per cycle sustained while rsp_ready
// is held high. An input byte is classified in the front end, parked in a
// two-entry queue, and resolved by the framing state machine into the result
// register. The queue lets input keep flowing while a result waits, until it
// fills. skip_header takes effect at the next start_message; reset sets it to 1.
module http_chunked_body_decoder import hcbd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       start_message,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic [1:0]      status
);

  logic    skip_header;
  logic    push;
  logic    pop;
  item_t   push_item;
  item_t   head;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_header <= 1'b1;
    end else if (cfg_we) begin
      skip_header <= cfg_wdata;
    end
  end

  hcbd_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .start_message (start_message),
    .q_stat        (q_stat),
    .push          (push),
    .item          (push_item)
  );

  hcbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  hcbd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .skip_header (skip_header),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .out_byte    (out_byte),
    .out_valid   (out_valid),
    .status      (status)
  );

  // body bytes only come out while framing is in progress
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_valid |-> status == STATUS_FRAMING)
    else $error("data beat with non-framing status");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !out_valid |-> out_byte == 8'd0)
    else $error("non-data beat carries a byte");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !q_stat.empty)
    else $error("queue lost a pushed beat");

endmodule
`default_nettype wire

@@ hdl/hcbd_front.sv @@
// Front end: takes input beats and classifies each byte for the back end.
`timescale 1ns / 1ps
`default_nettype none
module hcbd_front import hcbd_pkg::*; (
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       start_message,
  input  wire q_stat_t    q_stat,
  output logic            push,
  output item_t           item
);

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    item.data    = in_byte;
    item.start   = start_message;
    item.is_cr   = (in_byte == CH_CR);
    item.is_lf   = (in_byte == CH_LF);
    item.is_hex  = 1'b0;
    item.hex_val = 4'd0;
    case (in_byte) inside
      ["0":"9"]: begin
        item.is_hex  = 1'b1;
        item.hex_val = 4'(in_byte - 8'h30);
      end
      ["a":"f"]: begin
        item.is_hex  = 1'b1;
        item.hex_val = 4'(in_byte - 8'h57);
      end
      ["A":"F"]: begin
        item.is_hex  = 1'b1;
        item.hex_val = 4'(in_byte - 8'h37);
      end
      default: begin
        item.is_hex  = 1'b0;
        item.hex_val = 4'd0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/hcbd_queue.sv @@
// Small register queue between the classifier and the framing engine.
`timescale 1ns / 1ps
`default_nettype none
module hcbd_queue import hcbd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output q_stat_t    q_stat
);

  item_t                 entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] count;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = (count == Q_CNT_BITS'(Q_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/hcbd_back.sv @@
// Back end: chunked framing state machine and the result register.
`timescale 1ns / 1ps
`default_nettype none
module hcbd_back import hcbd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       skip_header,
  input  wire item_t      head,
  input  wire q_stat_t    q_stat,
  output logic            pop,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic [1:0]      status
);

  phase_t                phase, phase_next;
  logic [1:0]            blm, blm_next;
  logic [SIZE_BITS-1:0]  remaining, remaining_next;
  logic [CNT_BITS-1:0]   digits, digits_next;
  logic                  valid_next;

  phase_t                ph_cur;
  logic [1:0]            blm_cur;
  logic [SIZE_BITS-1:0]  rem_cur;
  logic [SIZE_BITS-1:0]  rem_dec;
  logic [CNT_BITS-1:0]   dig_cur;
  logic                  hdr_hit;

  assign pop = !q_stat.empty && (!rsp_valid || rsp_ready);

  always_comb begin
    // start_message restarts the parser ahead of this byte
    ph_cur  = head.start ? (skip_header ? PH_HEADER : PH_SIZE) : phase;
    blm_cur = head.start ? 2'd0 : blm;
    rem_cur = head.start ? '0 : remaining;
    dig_cur = head.start ? '0 : digits;
    rem_dec = rem_cur - 1'b1;
    hdr_hit = blm_cur[0] ? head.is_lf : head.is_cr;

    phase_next     = ph_cur;
    blm_next       = blm_cur;
    remaining_next = rem_cur;
    digits_next    = dig_cur;
    valid_next     = 1'b0;

    case (ph_cur)
      PH_HEADER: begin
        if (hdr_hit) begin
          if (blm_cur == 2'd3) begin
            blm_next   = 2'd0;
            phase_next = PH_SIZE;
          end else begin
            blm_next = blm_cur + 1'b1;
          end
        end else begin
          blm_next = head.is_cr ? 2'd1 : 2'd0;
        end
      end
      PH_SIZE: begin
        if (head.is_hex) begin
          // a further digit would overflow the size field
          if (rem_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_next = PH_ERROR;
          end else begin
            remaining_next = {rem_cur[SIZE_BITS-5:0], head.hex_val};
            if (dig_cur != CNT_MAX) digits_next = dig_cur + 1'b1;
          end
        end else if (head.is_cr && dig_cur != '0) begin
          phase_next = PH_SIZE_LF;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_SIZE_LF: begin
        if (!head.is_lf)        phase_next = PH_ERROR;
        else if (rem_cur == '0) phase_next = PH_DONE;
        else                    phase_next = PH_DATA;
        digits_next = '0;
      end
      PH_DATA: begin
        valid_next     = 1'b1;
        remaining_next = rem_dec;
        if (rem_dec == '0) phase_next = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        phase_next = head.is_cr ? PH_DATA_LF : PH_ERROR;
      end
      PH_DATA_LF: begin
        phase_next     = head.is_lf ? PH_SIZE : PH_ERROR;
        remaining_next = '0;
        digits_next    = '0;
      end
      default: begin
        phase_next = ph_cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      blm       <= 2'd0;
      remaining <= '0;
      digits    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase     <= phase_next;
        blm       <= blm_next;
        remaining <= remaining_next;
        digits    <= digits_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_valid <= valid_next;
      out_byte  <= valid_next ? head.data : 8'd0;
      status    <= status_of(phase_next);
    end
  end

endmodule
`default_nettype wire
